[rtl/signed_days_between_dates_defines.svh]
// Assertion macros shared by the checker of the signed day-count block.
`ifndef SIGNED_DAYS_BETWEEN_DATES_DEFINES_SVH
`define SIGNED_DAYS_BETWEEN_DATES_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SDBD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SDBD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/sdbd_pkg.sv]
// Shared widths, constants, types and calendar functions of the day-count block.
package sdbd_pkg;

  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int DIFF_W  = 23;
  localparam int YY_W    = 15;   // shifted year, up to 16783
  localparam int SER_W   = 23;   // serial day number
  localparam int PROD_W  = 28;   // YY_W x reciprocal
  localparam int RECIP_W = 13;
  localparam int Q_W     = 8;    // quotient by 100
  localparam int DOY_W   = 10;

  // Reciprocal of 100 scaled by 2^19; exact floor for every operand below 2^15.
  localparam logic [RECIP_W-1:0] RECIP_100   = 13'd5243;
  localparam int                 RECIP_SHIFT = 19;
  localparam logic [YY_W-1:0]    YEAR_SHIFT  = 15'd400;
  localparam logic signed [DIFF_W:0] DIFF_LIMIT = 24'sd3652426;

  typedef struct packed {
    logic load;    // capture the input beat
    logic sel;     // 0: first date, 1: second date
    logic mul_y;   // multiply plain year by reciprocal
    logic mul_yy;  // multiply shifted year, check date, form base sum
    logic sum;     // finish serial day number of the selected date
    logic finish;  // form the result and load the output register
  } dp_cmd_t;

  typedef struct packed {
    logic out_busy;  // output register holds a beat that is not taken
  } dp_sts_t;

  // Days from March 1 to the first of the month, year starting in March.
  function automatic logic [8:0] month_start(input logic [MONTH_W-1:0] m);
    logic [8:0] s;
    case (m)
      4'd3:    s = 9'd0;
      4'd4:    s = 9'd31;
      4'd5:    s = 9'd61;
      4'd6:    s = 9'd92;
      4'd7:    s = 9'd122;
      4'd8:    s = 9'd153;
      4'd9:    s = 9'd184;
      4'd10:   s = 9'd214;
      4'd11:   s = 9'd245;
      4'd12:   s = 9'd275;
      4'd1:    s = 9'd306;
      4'd2:    s = 9'd337;
      default: s = 9'd0;
    endcase
    return s;
  endfunction

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    case (m) inside
      4'd2:                     len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:  len = 5'd30;
      default:                  len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

[rtl/sdbd_channels.sv]
// Valid/ready channel interfaces for the input dates and the day-count result.
interface sdbd_in_if;
  import sdbd_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [YEAR_W-1:0]    first_year;
  logic [MONTH_W-1:0]   first_month;
  logic [DAY_W-1:0]     first_day;
  logic [YEAR_W-1:0]    second_year;
  logic [MONTH_W-1:0]   second_month;
  logic [DAY_W-1:0]     second_day;
  logic                 include_end_day;

  modport source (output valid, first_year, first_month, first_day, second_year,
                  second_month, second_day, include_end_day, input ready);
  modport sink   (input valid, first_year, first_month, first_day, second_year,
                  second_month, second_day, include_end_day, output ready);
endinterface

interface sdbd_out_if;
  import sdbd_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [DIFF_W-1:0] day_difference;
  logic                     date_invalid;

  modport source (output valid, day_difference, date_invalid, input ready);
  modport sink   (input valid, day_difference, date_invalid, output ready);
endinterface

[rtl/sdbd_ctrl.sv]
// Controller that sequences the two date conversions and the final subtraction.
module sdbd_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  sdbd_pkg::dp_sts_t sts,
  output sdbd_pkg::dp_cmd_t cmd
);
  import sdbd_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_MUL_Y  = 3'd1;
  localparam logic [2:0] ST_MUL_YY = 3'd2;
  localparam logic [2:0] ST_SUM    = 3'd3;
  localparam logic [2:0] ST_FINISH = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       sel_r, sel_nxt;

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt  = state_r;
    sel_nxt    = sel_r;
    cmd        = '0;
    cmd.sel    = sel_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          sel_nxt   = 1'b0;
          state_nxt = ST_MUL_Y;
        end
      end
      ST_MUL_Y: begin
        cmd.mul_y = 1'b1;
        state_nxt = ST_MUL_YY;
      end
      ST_MUL_YY: begin
        cmd.mul_yy = 1'b1;
        state_nxt  = ST_SUM;
      end
      ST_SUM: begin
        cmd.sum = 1'b1;
        if (sel_r) begin
          state_nxt = ST_FINISH;
        end else begin
          sel_nxt   = 1'b1;
          state_nxt = ST_MUL_Y;
        end
      end
      ST_FINISH: begin
        if (!sts.out_busy) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      sel_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      sel_r   <= sel_nxt;
    end
  end

endmodule

[rtl/sdbd_datapath.sv]
// Datapath: serial day numbers through a shared reciprocal multiplier, then the signed result.
module sdbd_datapath (
  input  logic                           clk,
  input  logic                           rst_n,
  input  sdbd_pkg::dp_cmd_t              cmd,
  output sdbd_pkg::dp_sts_t              sts,
  input  logic [sdbd_pkg::YEAR_W-1:0]    in_first_year,
  input  logic [sdbd_pkg::MONTH_W-1:0]   in_first_month,
  input  logic [sdbd_pkg::DAY_W-1:0]     in_first_day,
  input  logic [sdbd_pkg::YEAR_W-1:0]    in_second_year,
  input  logic [sdbd_pkg::MONTH_W-1:0]   in_second_month,
  input  logic [sdbd_pkg::DAY_W-1:0]     in_second_day,
  input  logic                           in_include_end_day,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [sdbd_pkg::DIFF_W-1:0] out_day_difference,
  output logic                           out_date_invalid
);
  import sdbd_pkg::*;

  logic [YEAR_W-1:0]  y1_r, y2_r;
  logic [MONTH_W-1:0] m1_r, m2_r;
  logic [DAY_W-1:0]   d1_r, d2_r;
  logic               inc_r;
  logic [PROD_W-1:0]  prod_r;
  logic [SER_W-1:0]   base_r, day1_r, day2_r;
  logic               bad_r;
  logic               out_valid_r;
  logic signed [DIFF_W-1:0] diff_out_r;
  logic               invalid_out_r;

  logic [YEAR_W-1:0]  y_s;
  logic [MONTH_W-1:0] m_s;
  logic [DAY_W-1:0]   d_s;
  logic [YY_W-1:0]    yy;
  logic [YY_W-1:0]    mul_a;
  logic [Q_W-1:0]     q;
  logic [YY_W-1:0]    q_x100;
  logic [YY_W-1:0]    rem;
  logic               leap;
  logic [DAY_W-1:0]   len;
  logic               ok;
  logic [DOY_W-1:0]   doy;
  logic [SER_W-1:0]   base_nxt;
  logic [SER_W-1:0]   day_nxt;
  logic signed [DIFF_W:0] diff, res, res_sat;

  assign y_s = cmd.sel ? y2_r : y1_r;
  assign m_s = cmd.sel ? m2_r : m1_r;
  assign d_s = cmd.sel ? d2_r : d1_r;

  // January and February count as months of the previous year.
  assign yy    = YY_W'(y_s) + YEAR_SHIFT - ((m_s <= 4'd2) ? 15'd1 : 15'd0);
  assign mul_a = cmd.mul_y ? YY_W'(y_s) : yy;

  // prod_r holds year/100 scaled: of the plain year after mul_y, of yy after mul_yy.
  assign q      = prod_r[RECIP_SHIFT +: Q_W];
  assign q_x100 = YY_W'(q) * 15'd100;
  assign rem    = YY_W'(y_s) - q_x100;
  assign leap   = (rem == '0) ? (q[1:0] == 2'b00) : (y_s[1:0] == 2'b00);
  assign len    = month_len(m_s, leap);
  assign ok     = (m_s >= 4'd1) && (m_s <= 4'd12) && (d_s != '0) && (d_s <= len);

  assign doy      = DOY_W'(month_start(m_s)) + DOY_W'(d_s) - 10'd1;
  assign base_nxt = SER_W'(yy) * 23'd365 + SER_W'(yy >> 2) + SER_W'(doy);
  assign day_nxt  = base_r - SER_W'(q) + SER_W'(q >> 2);

  always_comb begin
    diff = $signed({1'b0, day2_r}) - $signed({1'b0, day1_r});
    if (diff > 0) begin
      res = diff + $signed({{DIFF_W{1'b0}}, inc_r});
    end else begin
      res = diff - $signed({{DIFF_W{1'b0}}, inc_r});
    end
    if (res > DIFF_LIMIT) begin
      res_sat = DIFF_LIMIT;
    end else if (res < -DIFF_LIMIT) begin
      res_sat = -DIFF_LIMIT;
    end else begin
      res_sat = res;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      y1_r  <= in_first_year;
      m1_r  <= in_first_month;
      d1_r  <= in_first_day;
      y2_r  <= in_second_year;
      m2_r  <= in_second_month;
      d2_r  <= in_second_day;
      inc_r <= in_include_end_day;
    end
    if (cmd.mul_y || cmd.mul_yy) begin
      prod_r <= PROD_W'(mul_a) * PROD_W'(RECIP_100);
    end
    if (cmd.mul_yy) begin
      base_r <= base_nxt;
      bad_r  <= (cmd.sel ? bad_r : 1'b0) | !ok;
    end
    if (cmd.sum) begin
      if (cmd.sel) begin
        day2_r <= day_nxt;
      end else begin
        day1_r <= day_nxt;
      end
    end
    if (cmd.finish) begin
      diff_out_r    <= bad_r ? '0 : res_sat[DIFF_W-1:0];
      invalid_out_r <= bad_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign sts.out_busy       = out_valid_r && !out_ready;
  assign out_valid          = out_valid_r;
  assign out_day_difference = diff_out_r;
  assign out_date_invalid   = invalid_out_r;

endmodule

[rtl/signed_days_between_dates.sv]
// The controller runs each date through the shared reciprocal multiplier in three
// steps, then one subtract step, which waits while the output register is blocked.
// A new date pair is taken only once the previous pair has reached the output register.
// A new input beat is taken while the previous result still waits in the output register.
// Reset (rst_n low, synchronous) returns the controller to idle and empties the output.
module signed_days_between_dates (
  input logic        clk,
  input logic        rst_n,
  sdbd_in_if.sink    in_ch,
  sdbd_out_if.source out_ch
);
  import sdbd_pkg::*;

  // The controller issues one command word per cycle; the datapath reports
  // only whether its output register is blocked by the downstream side.
  dp_cmd_t cmd;
  dp_sts_t sts;
  logic    ready;

  sdbd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Each date becomes a serial day number counted from a year shifted by 400,
  // so that every intermediate term stays non-negative. Division by 100 uses a
  // scaled reciprocal; division by 4 is a shift of the year, by 400 a shift of the quotient by 100.
  sdbd_datapath u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_first_year      (in_ch.first_year),
    .in_first_month     (in_ch.first_month),
    .in_first_day       (in_ch.first_day),
    .in_second_year     (in_ch.second_year),
    .in_second_month    (in_ch.second_month),
    .in_second_day      (in_ch.second_day),
    .in_include_end_day (in_ch.include_end_day),
    .out_valid          (out_ch.valid),
    .out_ready          (out_ch.ready),
    .out_day_difference (out_ch.day_difference),
    .out_date_invalid   (out_ch.date_invalid)
  );

  // The input side is ready only while the controller is idle.
  assign in_ch.ready = ready;

endmodule

[rtl/sdbd_checker.sv]
// Port-level checker for the signed day-count block and its bind statement.
`include "signed_days_between_dates_defines.svh"

module sdbd_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic signed [sdbd_pkg::DIFF_W-1:0] out_day_difference,
  input logic                               out_date_invalid
);
  import sdbd_pkg::*;

  `SDBD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_day_difference) && $stable(out_date_invalid), "stalled result beat changed")
  `SDBD_ASSERT_NOW(a_invalid_zero, clk, rst_n, out_valid && out_date_invalid, out_day_difference == '0, "invalid date with nonzero difference")
  `SDBD_ASSERT_NOW(a_bound, clk, rst_n, out_valid, (out_day_difference <= DIFF_LIMIT) && (out_day_difference >= -DIFF_LIMIT), "difference outside saturation bound")
  `SDBD_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready, "input accepted while a date pair is in work")

endmodule

bind signed_days_between_dates sdbd_checker u_sdbd_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_ch.valid),
  .in_ready           (in_ch.ready),
  .out_valid          (out_ch.valid),
  .out_ready          (out_ch.ready),
  .out_day_difference (out_ch.day_difference),
  .out_date_invalid   (out_ch.date_invalid)
);
